### src/spo_pkg.sv
`timescale 1ns / 1ps
// spo_pkg: shared types for the shape pair overlap test
// test kind codes and the control bundle that travels down the pipeline
// no dependencies
package spo_pkg;

	// which pair of shapes a request carries
	typedef enum logic [1:0] {
		KIND_BOX_BOX   = 2'd0,
		KIND_CIRC_CIRC = 2'd1,
		KIND_BOX_CIRC  = 2'd2,
		KIND_CIRC_BOX  = 2'd3
	} kind_t;

	// per-stage control: valid flag, box-box request flag, box-box answer
	typedef struct packed {
		logic vld;
		logic is_box;
		logic box_hit;
	} ctl_t;

endpackage

### src/spo_front.sv
`timescale 1ns / 1ps
// spo_front: request register, box-box interval test and operand setup
// selects point and interval per axis plus the radius; depends on spo_pkg
module spo_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [1:0]                   kind,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic [COORD_BITS-2:0]        a_w,
	input  logic [COORD_BITS-2:0]        a_h,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic [COORD_BITS-2:0]        b_w,
	input  logic [COORD_BITS-2:0]        b_h,
	output spo_pkg::ctl_t                ctl_s2,
	output logic signed [COORD_BITS:0]   vx_s2,
	output logic signed [COORD_BITS:0]   vy_s2,
	output logic signed [COORD_BITS:0]   lox_s2,
	output logic signed [COORD_BITS:0]   hix_s2,
	output logic signed [COORD_BITS:0]   loy_s2,
	output logic signed [COORD_BITS:0]   hiy_s2,
	output logic [COORD_BITS-1:0]        rad_s2
);
	import spo_pkg::*;

	localparam int W = COORD_BITS;

	logic                vld_s1;
	kind_t               kind_s1;
	logic signed [W-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic [W-2:0]        aw_s1, ah_s1, bw_s1, bh_s1;

	logic signed [W:0] ax_e, ay_e, bx_e, by_e;
	logic signed [W:0] aw_e, ah_e, bw_e, bh_e;
	logic signed [W:0] sax, say, sbx, sby, hay, hby;
	logic signed [W:0] tx, ty, txn, tyn;
	logic              box_hit_c;
	logic signed [W:0] vx_c, vy_c, lox_c, hix_c, loy_c, hiy_c;
	logic [W-1:0]      rad_c;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= kind_t'(kind);
			ax_s1   <= a_x;
			ay_s1   <= a_y;
			aw_s1   <= a_w;
			ah_s1   <= a_h;
			bx_s1   <= b_x;
			by_s1   <= b_y;
			bw_s1   <= b_w;
			bh_s1   <= b_h;
		end
	end

	// extend everything to one signed width
	assign ax_e = {ax_s1[W-1], ax_s1};
	assign ay_e = {ay_s1[W-1], ay_s1};
	assign bx_e = {bx_s1[W-1], bx_s1};
	assign by_e = {by_s1[W-1], by_s1};
	assign aw_e = {2'b00, aw_s1};
	assign ah_e = {2'b00, ah_s1};
	assign bw_e = {2'b00, bw_s1};
	assign bh_e = {2'b00, bh_s1};

	// corner plus extent sums (circle centers and far box edges)
	assign sax = ax_e + aw_e;
	assign say = ay_e + aw_e;
	assign sbx = bx_e + bw_e;
	assign sby = by_e + bw_e;
	assign hay = ay_e + ah_e;
	assign hby = by_e + bh_e;

	// box-box interval test, touching counts
	assign tx  = ax_e - bx_e;
	assign ty  = ay_e - by_e;
	assign txn = bx_e - ax_e;
	assign tyn = by_e - ay_e;
	assign box_hit_c = (tx <= bw_e) && (txn <= aw_e) && (ty <= bh_e) && (tyn <= ah_e);

	// point against interval per axis; circle-circle uses a degenerate interval
	always_comb begin
		unique case (kind_s1)
			KIND_CIRC_CIRC: begin
				vx_c  = sax;
				vy_c  = say;
				lox_c = sbx;
				hix_c = sbx;
				loy_c = sby;
				hiy_c = sby;
				rad_c = {1'b0, aw_s1} + {1'b0, bw_s1};
			end
			KIND_CIRC_BOX: begin
				vx_c  = sax;
				vy_c  = say;
				lox_c = bx_e;
				hix_c = sbx;
				loy_c = by_e;
				hiy_c = hby;
				rad_c = {1'b0, aw_s1};
			end
			KIND_BOX_CIRC, KIND_BOX_BOX: begin
				vx_c  = sbx;
				vy_c  = sby;
				lox_c = ax_e;
				hix_c = sax;
				loy_c = ay_e;
				hiy_c = hay;
				rad_c = {1'b0, bw_s1};
			end
			default: begin
				vx_c  = sbx;
				vy_c  = sby;
				lox_c = ax_e;
				hix_c = sax;
				loy_c = ay_e;
				hiy_c = hay;
				rad_c = {1'b0, bw_s1};
			end
		endcase
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.vld     <= vld_s1;
			ctl_s2.is_box  <= (kind_s1 == KIND_BOX_BOX);
			ctl_s2.box_hit <= box_hit_c;
		end
	end

	always_ff @(posedge clk) begin
		vx_s2  <= vx_c;
		vy_s2  <= vy_c;
		lox_s2 <= lox_c;
		hix_s2 <= hix_c;
		loy_s2 <= loy_c;
		hiy_s2 <= hiy_c;
		rad_s2 <= rad_c;
	end

endmodule

### src/spo_gap.sv
`timescale 1ns / 1ps
// spo_gap: distance from a point to an interval on each axis
// zero inside the interval, else the distance to the nearer end; depends on spo_pkg
module spo_gap #(
	parameter int COORD_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spo_pkg::ctl_t              ctl_s2,
	input  logic signed [COORD_BITS:0] vx_s2,
	input  logic signed [COORD_BITS:0] vy_s2,
	input  logic signed [COORD_BITS:0] lox_s2,
	input  logic signed [COORD_BITS:0] hix_s2,
	input  logic signed [COORD_BITS:0] loy_s2,
	input  logic signed [COORD_BITS:0] hiy_s2,
	input  logic [COORD_BITS-1:0]      rad_s2,
	output spo_pkg::ctl_t              ctl_s3,
	output logic [COORD_BITS:0]        gx_s3,
	output logic [COORD_BITS:0]        gy_s3,
	output logic [COORD_BITS-1:0]      rad_s3
);
	import spo_pkg::*;

	localparam int W = COORD_BITS;

	logic [W:0] gx_c, gy_c;

	// one compare and subtract on each side of the interval
	function automatic logic [W:0] gap_of(input logic signed [W:0] v,
	                                      input logic signed [W:0] lo,
	                                      input logic signed [W:0] hi);
		logic signed [W+1:0] dlo;
		logic signed [W+1:0] dhi;
		logic [W:0]          g;
		dlo = {lo[W], lo} - {v[W], v};
		dhi = {v[W], v} - {hi[W], hi};
		priority if (v < lo) begin
			g = dlo[W:0];
		end else if (v > hi) begin
			g = dhi[W:0];
		end else begin
			g = '0;
		end
		return g;
	endfunction

	assign gx_c = gap_of(vx_s2, lox_s2, hix_s2);
	assign gy_c = gap_of(vy_s2, loy_s2, hiy_s2);

	// stage 3 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		gx_s3  <= gx_c;
		gy_s3  <= gy_c;
		rad_s3 <= rad_s2;
	end

endmodule

### src/spo_square.sv
`timescale 1ns / 1ps
// spo_square: squares of both axis gaps and of the radius
// three parallel multipliers, each registered; depends on spo_pkg
module spo_square #(
	parameter int COORD_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spo_pkg::ctl_t               ctl_s3,
	input  logic [COORD_BITS:0]         gx_s3,
	input  logic [COORD_BITS:0]         gy_s3,
	input  logic [COORD_BITS-1:0]       rad_s3,
	output spo_pkg::ctl_t               ctl_s4,
	output logic [2*COORD_BITS+1:0]     gx2_s4,
	output logic [2*COORD_BITS+1:0]     gy2_s4,
	output logic [2*COORD_BITS-1:0]     rad2_s4
);
	import spo_pkg::*;

	localparam int W  = COORD_BITS;
	localparam int PW = 2 * W + 2;
	localparam int RW = 2 * W;

	logic [PW-1:0] gx2_c, gy2_c;
	logic [RW-1:0] rad2_c;

	// full width products, nothing dropped
	assign gx2_c  = PW'(gx_s3) * PW'(gx_s3);
	assign gy2_c  = PW'(gy_s3) * PW'(gy_s3);
	assign rad2_c = RW'(rad_s3) * RW'(rad_s3);

	// stage 4 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		gx2_s4  <= gx2_c;
		gy2_s4  <= gy2_c;
		rad2_s4 <= rad2_c;
	end

endmodule

### src/spo_decide.sv
`timescale 1ns / 1ps
// spo_decide: squared distance against squared radius, result register
// picks the box-box answer for box pairs; depends on spo_pkg
module spo_decide #(
	parameter int COORD_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  spo_pkg::ctl_t           ctl_s4,
	input  logic [2*COORD_BITS+1:0] gx2_s4,
	input  logic [2*COORD_BITS+1:0] gy2_s4,
	input  logic [2*COORD_BITS-1:0] rad2_s4,
	output logic                    done_q,
	output logic                    hit_q
);
	import spo_pkg::*;

	localparam int SW = 2 * COORD_BITS + 3;

	logic [SW-1:0] dist2_c;
	logic          near_c;

	// sum of squared gaps, touching counts
	assign dist2_c = SW'(gx2_s4) + SW'(gy2_s4);
	assign near_c  = dist2_c <= SW'(rad2_s4);

	// result register, hit holds between results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= ctl_s4.vld;
			if (ctl_s4.vld) begin
				hit_q <= ctl_s4.is_box ? ctl_s4.box_hit : near_c;
			end
		end
	end

endmodule

### src/shape_pair_overlap_test.sv
`timescale 1ns / 1ps
// shape_pair_overlap_test: top level of the 2d box and circle overlap test
// depends on spo_pkg, spo_front, spo_gap, spo_square, spo_decide
//
// Usage
//   A request is taken at a rising edge where start is high and busy is low.
//   It carries kind and the corner and extents of shapes a and b in signed
//   fixed point; for a circle the first extent is the radius.
//   busy never rises: a new request can be taken on every clock.
//   Each request gives exactly one result: hit with done high for one cycle.
//   Results come out in request order, one per cycle at most.
//   The pipeline runs: request register, operand sums, axis
//   gaps, squaring multipliers, then the compare into the result register.
//   The receiver cannot stall; a result must be taken in its done cycle.
//   hit keeps its last value between results.
//   Reset clears all valid flags and the result register; requests in
//   flight are dropped.
module shape_pair_overlap_test #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic [COORD_BITS-2:0]        a_w,
	input  logic [COORD_BITS-2:0]        a_h,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic [COORD_BITS-2:0]        b_w,
	input  logic [COORD_BITS-2:0]        b_h,
	output logic                         done,
	output logic                         hit
);
	import spo_pkg::*;

	localparam int W = COORD_BITS;

	ctl_t              ctl_s2, ctl_s3, ctl_s4;
	logic signed [W:0] vx_s2, vy_s2, lox_s2, hix_s2, loy_s2, hiy_s2;
	logic [W-1:0]      rad_s2, rad_s3;
	logic [W:0]        gx_s3, gy_s3;
	logic [2*W+1:0]    gx2_s4, gy2_s4;
	logic [2*W-1:0]    rad2_s4;
	logic              take;

	// fully pipelined, always ready
	assign busy = 1'b0;
	assign take = start && !busy;

	spo_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.kind   (kind),
		.a_x    (a_x),
		.a_y    (a_y),
		.a_w    (a_w),
		.a_h    (a_h),
		.b_x    (b_x),
		.b_y    (b_y),
		.b_w    (b_w),
		.b_h    (b_h),
		.ctl_s2 (ctl_s2),
		.vx_s2  (vx_s2),
		.vy_s2  (vy_s2),
		.lox_s2 (lox_s2),
		.hix_s2 (hix_s2),
		.loy_s2 (loy_s2),
		.hiy_s2 (hiy_s2),
		.rad_s2 (rad_s2)
	);

	spo_gap #(.COORD_BITS(COORD_BITS)) u_gap (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.vx_s2  (vx_s2),
		.vy_s2  (vy_s2),
		.lox_s2 (lox_s2),
		.hix_s2 (hix_s2),
		.loy_s2 (loy_s2),
		.hiy_s2 (hiy_s2),
		.rad_s2 (rad_s2),
		.ctl_s3 (ctl_s3),
		.gx_s3  (gx_s3),
		.gy_s3  (gy_s3),
		.rad_s3 (rad_s3)
	);

	spo_square #(.COORD_BITS(COORD_BITS)) u_square (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s3  (ctl_s3),
		.gx_s3   (gx_s3),
		.gy_s3   (gy_s3),
		.rad_s3  (rad_s3),
		.ctl_s4  (ctl_s4),
		.gx2_s4  (gx2_s4),
		.gy2_s4  (gy2_s4),
		.rad2_s4 (rad2_s4)
	);

	spo_decide #(.COORD_BITS(COORD_BITS)) u_decide (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s4  (ctl_s4),
		.gx2_s4  (gx2_s4),
		.gy2_s4  (gy2_s4),
		.rad2_s4 (rad2_s4),
		.done_q  (done),
		.hit_q   (hit)
	);

endmodule

### src/spo_checker.sv
`timescale 1ns / 1ps
// spo_checker: port level checks on request and result timing
// bound to shape_pair_overlap_test; sees its ports only
module spo_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic hit
);

	// the pipeline takes a request on every clock
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// every request yields a result
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("request without result");

	// no result without an earlier request
	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without request");

	// hit only moves together with a result strobe
	a_hit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(hit) |-> done)
		else $error("hit changed outside a result");

endmodule

bind shape_pair_overlap_test spo_checker u_spo_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.hit    (hit)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for shape_pair_overlap_test, directed table then random pairs
// every hit is checked in request order, against a typed-in answer or a behavioral overlap predictor
// depends on spo_pkg and shape_pair_overlap_test
module tb_top;
	import spo_pkg::*;

	localparam int CB = 24;
	localparam int N_RANDOM = 1000;
	localparam int WATCHDOG_LIMIT = 500;

	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-2:0] EMAX = {(CB-1){1'b1}};

	// one request: test kind plus corner and extents of both shapes
	typedef struct packed {
		kind_t kind;
		logic signed [CB-1:0] a_x;
		logic signed [CB-1:0] a_y;
		logic [CB-2:0] a_w;
		logic [CB-2:0] a_h;
		logic signed [CB-1:0] b_x;
		logic signed [CB-1:0] b_y;
		logic [CB-2:0] b_w;
		logic [CB-2:0] b_h;
	} shape_pair_t;

	// directed row: the pair, and a typed-in answer where it is obvious
	typedef struct packed {
		shape_pair_t pair;
		bit typed;
		bit hit;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] kind;
	logic signed [CB-1:0] a_x, a_y, b_x, b_y;
	logic [CB-2:0] a_w, a_h, b_w, b_h;
	logic done;
	logic hit;

	bit predicted_hits[$];
	int mismatch_cnt;
	int idle_cycles;
	bit gapless;

	// edges, touching, one lsb apart, zero sizes and the coordinate extremes
	directed_row_t directed_rows [22] = '{
		'{'{KIND_BOX_BOX, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b1},
		'{'{KIND_BOX_BOX, 0, 0, 256, 256, 256, 0, 10, 10}, 1'b1, 1'b1},
		'{'{KIND_BOX_BOX, 0, 0, 256, 256, 257, 0, 10, 10}, 1'b1, 1'b0},
		'{'{KIND_BOX_BOX, 0, 100, 50, 50, 0, 0, 50, 100}, 1'b1, 1'b1},
		'{'{KIND_BOX_BOX, CMIN, CMIN, EMAX, EMAX, CMAX, CMAX, 0, 0}, 1'b1, 1'b0},
		'{'{KIND_BOX_BOX, CMIN, CMIN, EMAX, EMAX, -1, -1, 0, 0}, 1'b1, 1'b1},
		'{'{KIND_BOX_BOX, 0, 0, 0, 0, CMIN, CMIN, EMAX, EMAX}, 1'b1, 1'b0},
		'{'{KIND_CIRC_CIRC, 0, 0, 512, EMAX, 512, 768, 768, 0}, 1'b1, 1'b1},
		'{'{KIND_CIRC_CIRC, 0, 0, 512, EMAX, 513, 768, 768, 0}, 1'b1, 1'b0},
		'{'{KIND_CIRC_CIRC, -300, 77, 0, EMAX, -300, 77, 0, EMAX}, 1'b1, 1'b1},
		'{'{KIND_CIRC_CIRC, CMIN, CMIN, EMAX, 0, CMAX, CMAX, EMAX, 0}, 1'b1, 1'b0},
		'{'{KIND_BOX_CIRC, 0, 0, 1024, 1024, 1024, 0, 256, 0}, 1'b1, 1'b1},
		'{'{KIND_BOX_CIRC, 0, 0, 1024, 1024, 1025, 0, 256, 0}, 1'b1, 1'b0},
		'{'{KIND_BOX_CIRC, 0, 0, 1024, 1024, 512, 768, 1280, 0}, 1'b0, 1'b0},
		'{'{KIND_BOX_CIRC, 0, 0, 1024, 1024, 100, 100, 0, 0}, 1'b1, 1'b1},
		'{'{KIND_BOX_CIRC, -5, -5, 0, 0, -5, -5, 0, EMAX}, 1'b1, 1'b1},
		'{'{KIND_CIRC_BOX, 1024, 0, 256, 0, 0, 0, 1024, 1024}, 1'b1, 1'b1},
		'{'{KIND_CIRC_BOX, 512, 768, 1280, EMAX, 0, 0, 1024, 1024}, 1'b0, 1'b0},
		'{'{KIND_CIRC_BOX, CMAX, CMAX, EMAX, EMAX, CMIN, CMIN, EMAX, EMAX}, 1'b1, 1'b0},
		'{'{KIND_BOX_BOX, CMAX, CMIN, EMAX, 0, CMIN, CMAX, 0, EMAX}, 1'b0, 1'b0},
		'{'{KIND_BOX_CIRC, CMIN, CMIN, 0, 0, CMIN, CMIN, EMAX, EMAX}, 1'b0, 1'b0},
		'{'{KIND_CIRC_BOX, -1, -1, 1, 1, 0, 0, 0, 0}, 1'b0, 1'b0}
	};

	shape_pair_overlap_test #(
		.COORD_BITS(CB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.a_x(a_x),
		.a_y(a_y),
		.a_w(a_w),
		.a_h(a_h),
		.b_x(b_x),
		.b_y(b_y),
		.b_w(b_w),
		.b_h(b_h),
		.done(done),
		.hit(hit)
	);

	// squared distance from v to the interval [lo, lo + ext]
	function automatic longint axis_gap2(longint v, longint lo, longint ext);
		if (v < lo)
			return (lo - v) * (lo - v);
		if (v > lo + ext)
			return (v - lo - ext) * (v - lo - ext);
		return 0;
	endfunction

	// box against a circle whose centre is its corner plus the radius
	function automatic bit box_meets_circle(longint rx, longint ry, longint rw, longint rh,
			longint cx, longint cy, longint r);
		return axis_gap2(cx + r, rx, rw) + axis_gap2(cy + r, ry, rh) <= r * r;
	endfunction

	// exact overlap decision, all sums and squares held in 64 bits
	function automatic bit pair_overlaps(shape_pair_t p);
		longint ax, ay, aw, ah, bx, by, bw, bh, tx, ty, dx, dy;
		ax = p.a_x;
		ay = p.a_y;
		aw = p.a_w;
		ah = p.a_h;
		bx = p.b_x;
		by = p.b_y;
		bw = p.b_w;
		bh = p.b_h;
		case (p.kind)
			KIND_BOX_BOX: begin
				tx = ax - bx;
				ty = ay - by;
				return !(tx > bw || -tx > aw || ty > bh || -ty > ah);
			end
			KIND_CIRC_CIRC: begin
				dx = (ax + aw) - (bx + bw);
				dy = (ay + aw) - (by + bw);
				return dx * dx + dy * dy <= (aw + bw) * (aw + bw);
			end
			KIND_BOX_CIRC: return box_meets_circle(ax, ay, aw, ah, bx, by, bw);
			default: return box_meets_circle(bx, by, bw, bh, ax, ay, aw);
		endcase
	endfunction

	// optional random idle gap, then hold the request until it is taken and log its answer
	task automatic send_pair(input shape_pair_t p, input bit hit_want);
		int gap;
		gap = gapless ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 10));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= p.kind;
		a_x <= p.a_x;
		a_y <= p.a_y;
		a_w <= p.a_w;
		a_h <= p.a_h;
		b_x <= p.b_x;
		b_y <= p.b_y;
		b_w <= p.b_w;
		b_h <= p.b_h;
		do @(posedge clk); while (busy);
		predicted_hits = {predicted_hits, hit_want};
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result check against the oldest outstanding request
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (predicted_hits.size() == 0) begin
				$display("%0t: result with no request pending, expected none, got hit %0b",
					$time, hit);
				mismatch_cnt++;
			end else begin
				if (hit !== predicted_hits[0]) begin
					$display("%0t: hit mismatch, expected %0b, got %0b",
						$time, predicted_hits[0], hit);
					mismatch_cnt++;
				end
				void'(predicted_hits.pop_front());
			end
		end
	end

	// watchdog on cycles with neither a request taken nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus: reset, directed table, then random pairs
	initial begin
		shape_pair_t p;
		int mode, ext, span;
		arst_n = 1'b0;
		start = 1'b0;
		kind = '0;
		a_x = '0;
		a_y = '0;
		a_w = '0;
		a_h = '0;
		b_x = '0;
		b_y = '0;
		b_w = '0;
		b_h = '0;
		gapless = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i])
			send_pair(directed_rows[i].pair, directed_rows[i].typed ?
				directed_rows[i].hit : pair_overlaps(directed_rows[i].pair));

		for (int n = 0; n < N_RANDOM; n++) begin
			// back-to-back stretches now and then
			if (n % 64 == 0)
				gapless = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 9);
			p.kind = kind_t'($urandom_range(0, 3));
			p.a_x = CB'($urandom);
			p.a_y = CB'($urandom);
			if (mode < 2) begin
				// anything goes, every bit of every field
				p.a_w = (CB-1)'($urandom);
				p.a_h = (CB-1)'($urandom);
				p.b_x = CB'($urandom);
				p.b_y = CB'($urandom);
				p.b_w = (CB-1)'($urandom);
				p.b_h = (CB-1)'($urandom);
			end else begin
				// shapes near each other in one of three size ranges; the tiny one makes exact touches common
				if (mode < 6) begin
					ext = 32;
					span = 64;
				end else if (mode < 9) begin
					ext = 4096;
					span = 8192;
				end else begin
					ext = int'(EMAX);
					span = 1 << 22;
				end
				p.a_w = (CB-1)'($urandom_range(0, ext));
				p.a_h = (CB-1)'($urandom_range(0, ext));
				p.b_w = (CB-1)'($urandom_range(0, ext));
				p.b_h = (CB-1)'($urandom_range(0, ext));
				p.b_x = p.a_x + CB'(int'($urandom_range(0, 2 * span)) - span);
				p.b_y = p.a_y + CB'(int'($urandom_range(0, 2 * span)) - span);
			end
			send_pair(p, pair_overlaps(p));
		end
		start <= 1'b0;

		// drain, then watch for anything stray
		while (predicted_hits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
